// ===== rtl/gcwd_pkg.sv =====
// Shared types, codes and sizes for the graphics command word decoder.
`timescale 1ns / 1ps
`default_nettype none

package gcwd_pkg;

    localparam int DEF_VRAM_WIDTH  = 1024;
    localparam int DEF_VRAM_HEIGHT = 512;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        MODE_IDLE = 1'b0,
        MODE_WAIT = 1'b1
    } gcwd_mode_t;

    typedef enum logic [3:0] {
        EV_PARAM    = 4'd0,
        EV_WAIT     = 4'd1,
        EV_ENV      = 4'd2,
        EV_DRAW     = 4'd3,
        EV_FILL     = 4'd4,
        EV_VCOPY    = 4'd5,
        EV_TOVRAM   = 4'd6,
        EV_FROMVRAM = 4'd7,
        EV_NOP      = 4'd8,
        EV_POLYLINE = 4'd9,
        EV_INVALID  = 4'd10
    } gcwd_event_t;

    typedef enum logic [2:0] {
        CLS_MISC     = 3'd0,
        CLS_POLYGON  = 3'd1,
        CLS_LINE     = 3'd2,
        CLS_RECT     = 3'd3,
        CLS_VCOPY    = 3'd4,
        CLS_TOVRAM   = 3'd5,
        CLS_FROMVRAM = 3'd6,
        CLS_ENV      = 3'd7
    } gcwd_class_t;

    localparam logic [7:0] MISC_NOP         = 8'h00;
    localparam logic [7:0] MISC_CLEAR_CACHE = 8'h01;
    localparam logic [7:0] MISC_FILL        = 8'h02;
    localparam logic [7:0] MISC_NOP_ALT     = 8'h03;

    localparam logic [7:0] ENV_TPAGE  = 8'hE1;
    localparam logic [7:0] ENV_WINDOW = 8'hE2;
    localparam logic [7:0] ENV_AREA_TL = 8'hE3;
    localparam logic [7:0] ENV_AREA_BR = 8'hE4;
    localparam logic [7:0] ENV_OFFSET = 8'hE5;
    localparam logic [7:0] ENV_MASK   = 8'hE6;

    typedef struct packed {
        gcwd_event_t ev;
        gcwd_class_t cls;
        logic [3:0]  cnt;
        logic        flush;
        logic [15:0] c0_lo;
        logic [15:0] c0_hi;
        logic [15:0] c1_lo;
        logic [15:0] c1_hi;
        logic [15:0] sz_lo;
        logic [15:0] sz_hi;
    } gcwd_item_t;

endpackage

`default_nettype wire

// ===== rtl/gpu_command_word_decoder.sv =====
// Top level of the graphics command word decoder: front end, item queue and back end.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid / s_ready  s_word
//  m_       out        m_valid / m_ready  m_event_res, m_cmd_class, m_param_count, m_src_x,
//                                         m_src_y, m_dst_x, m_dst_y, m_width, m_height,
//                                         m_flush_needed
//
// Sustains one item per cycle while m_ready holds; each item yields one registered result.
// The front end decodes a word in the cycle it is accepted, so its command state loop sets
// the one-cycle rate. Synchronous reset returns the decoder to idle with the queue empty.
// A two-item queue and the output register absorb stalls on m_ready; s_ready drops only
// when the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module gpu_command_word_decoder import gcwd_pkg::*; #(
    parameter int VRAM_WIDTH  = DEF_VRAM_WIDTH,
    parameter int VRAM_HEIGHT = DEF_VRAM_HEIGHT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_event_res,
    output logic [2:0]       m_cmd_class,
    output logic [3:0]       m_param_count,
    output logic [9:0]       m_src_x,
    output logic [8:0]       m_src_y,
    output logic [9:0]       m_dst_x,
    output logic [8:0]       m_dst_y,
    output logic [10:0]      m_width,
    output logic [9:0]       m_height,
    output logic             m_flush_needed
);

    gcwd_item_t front_item;
    gcwd_item_t queue_item;
    logic       accept;
    logic       q_not_full;
    logic       q_not_empty;
    logic       q_pop;

    assign s_ready = q_not_full;
    assign accept  = s_valid && q_not_full;

    gcwd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .word    (s_word),
        .item    (front_item)
    );

    gcwd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_item (front_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .pop_item  (queue_item),
        .not_empty (q_not_empty)
    );

    gcwd_back #(
        .VRAM_WIDTH  (VRAM_WIDTH),
        .VRAM_HEIGHT (VRAM_HEIGHT)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_not_empty),
        .q_item         (queue_item),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_cmd_class    (m_cmd_class),
        .m_param_count  (m_param_count),
        .m_src_x        (m_src_x),
        .m_src_y        (m_src_y),
        .m_dst_x        (m_dst_x),
        .m_dst_y        (m_dst_y),
        .m_width        (m_width),
        .m_height       (m_height),
        .m_flush_needed (m_flush_needed)
    );

endmodule

`default_nettype wire

// ===== rtl/gcwd_front.sv =====
// Front end: accepts command words, tracks command state and classifies each item.
`timescale 1ns / 1ps
`default_nettype none

module gcwd_front import gcwd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        accept,
    input  wire logic [31:0] word,
    output gcwd_item_t       item
);

    gcwd_mode_t  mode_reg, mode_next;
    logic [3:0]  remaining_reg, remaining_next;
    gcwd_class_t cmd_cls_reg, cmd_cls_next;
    logic [1:0]  pidx_reg, pidx_next;
    logic [31:0] p0_reg, p0_next;
    logic [31:0] p1_reg, p1_next;
    logic [13:0] tpage_reg, tpage_next;
    logic [19:0] twin_reg, twin_next;
    logic [19:0] area_tl_reg, area_tl_next;
    logic [19:0] area_br_reg, area_br_next;
    logic [20:0] offset_reg, offset_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            remaining_reg <= 4'd0;
            cmd_cls_reg   <= CLS_MISC;
            pidx_reg      <= 2'd0;
            tpage_reg     <= 14'd0;
            twin_reg      <= 20'd0;
            area_tl_reg   <= 20'd0;
            area_br_reg   <= 20'd0;
            offset_reg    <= 21'd0;
        end else if (accept) begin
            mode_reg      <= mode_next;
            remaining_reg <= remaining_next;
            cmd_cls_reg   <= cmd_cls_next;
            pidx_reg      <= pidx_next;
            tpage_reg     <= tpage_next;
            twin_reg      <= twin_next;
            area_tl_reg   <= area_tl_next;
            area_br_reg   <= area_br_next;
            offset_reg    <= offset_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
        end
    end

    always_comb begin
        logic [7:0]  sub;
        logic [3:0]  n;
        logic [3:0]  nv;
        logic [3:0]  per;
        gcwd_class_t cls;

        sub = word[31:24];
        cls = gcwd_class_t'(word[31:29]);
        n   = 4'd0;
        nv  = word[27] ? 4'd4 : 4'd3;
        per = 4'd1 + {3'd0, word[26]} + {3'd0, word[28]};

        mode_next      = mode_reg;
        remaining_next = remaining_reg;
        cmd_cls_next   = cmd_cls_reg;
        pidx_next      = pidx_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        tpage_next     = tpage_reg;
        twin_next      = twin_reg;
        area_tl_next   = area_tl_reg;
        area_br_next   = area_br_reg;
        offset_next    = offset_reg;

        item.ev    = EV_INVALID;
        item.cls   = cls;
        item.cnt   = 4'd0;
        item.flush = 1'b0;
        item.c0_lo = p0_reg[15:0];
        item.c0_hi = p0_reg[31:16];
        item.c1_lo = p1_reg[15:0];
        item.c1_hi = p1_reg[31:16];
        item.sz_lo = word[15:0];
        item.sz_hi = word[31:16];

        unique case (mode_reg)
            MODE_WAIT: begin
                item.cls = cmd_cls_reg;
                if (pidx_reg == 2'd0) begin
                    p0_next = word;
                end
                if (pidx_reg == 2'd1) begin
                    p1_next = word;
                end
                if (pidx_reg != 2'd3) begin
                    pidx_next = pidx_reg + 2'd1;
                end
                if (remaining_reg != 4'd0) begin
                    remaining_next = remaining_reg - 4'd1;
                end
                item.cnt = remaining_next;
                if (remaining_next != 4'd0) begin
                    item.ev = EV_PARAM;
                end else begin
                    mode_next = MODE_IDLE;
                    unique case (cmd_cls_reg)
                        CLS_MISC:     item.ev = EV_FILL;
                        CLS_VCOPY:    item.ev = EV_VCOPY;
                        CLS_TOVRAM:   item.ev = EV_TOVRAM;
                        CLS_FROMVRAM: item.ev = EV_FROMVRAM;
                        default:      item.ev = EV_DRAW;
                    endcase
                end
            end
            MODE_IDLE: begin
                unique case (cls)
                    CLS_MISC: begin
                        unique case (sub) inside
                            MISC_NOP, MISC_NOP_ALT: item.ev = EV_NOP;
                            MISC_CLEAR_CACHE: begin
                                item.ev    = EV_NOP;
                                item.flush = 1'b1;
                            end
                            MISC_FILL: n = 4'd2;
                            default: item.ev = EV_INVALID;
                        endcase
                    end
                    CLS_POLYGON: n = 4'(nv * per) - {3'd0, word[28]};
                    CLS_LINE: begin
                        if (word[27]) begin
                            item.ev = EV_POLYLINE;
                        end else begin
                            n = word[28] ? 4'd3 : 4'd2;
                        end
                    end
                    CLS_RECT: begin
                        n = 4'd1 + {3'd0, word[28:27] == 2'b00} + {3'd0, word[26]};
                    end
                    CLS_VCOPY: n = 4'd3;
                    CLS_TOVRAM, CLS_FROMVRAM: n = 4'd2;
                    CLS_ENV: begin
                        item.ev = EV_ENV;
                        unique case (sub)
                            ENV_TPAGE: begin
                                tpage_next = word[13:0];
                                item.flush = (tpage_next != tpage_reg);
                            end
                            ENV_WINDOW: begin
                                twin_next  = word[19:0];
                                item.flush = (twin_next != twin_reg);
                            end
                            ENV_AREA_TL: begin
                                area_tl_next = word[19:0];
                                item.flush   = (area_tl_next != area_tl_reg);
                            end
                            ENV_AREA_BR: begin
                                area_br_next = word[19:0];
                                item.flush   = (area_br_next != area_br_reg);
                            end
                            ENV_OFFSET: begin
                                offset_next = word[20:0];
                                item.flush  = (offset_next != offset_reg);
                            end
                            ENV_MASK: item.flush = 1'b1;
                            default: item.ev = EV_INVALID;
                        endcase
                    end
                endcase
                if (n != 4'd0) begin
                    cmd_cls_next   = cls;
                    remaining_next = n;
                    pidx_next      = 2'd0;
                    mode_next      = MODE_WAIT;
                    item.ev        = EV_WAIT;
                    item.cnt       = n;
                end
            end
        endcase
    end

    a_wait_has_params: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_WAIT) |-> (remaining_reg != 4'd0))
        else $error("waiting for parameters with none left to count");

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_IDLE) |-> (remaining_reg == 4'd0))
        else $error("idle with parameters still outstanding");

    a_last_param_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && mode_reg == MODE_WAIT && remaining_reg == 4'd1) |=> (mode_reg == MODE_IDLE))
        else $error("last parameter did not return the decoder to idle");

endmodule

`default_nettype wire

// ===== rtl/gcwd_queue.sv =====
// Short item queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module gcwd_queue import gcwd_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire gcwd_item_t push_item,
    output logic            not_full,
    input  wire logic       pop,
    output gcwd_item_t      pop_item,
    output logic            not_empty
);

    gcwd_item_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign not_full  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (not_full || pop))
        else $error("item written into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("item taken from an empty queue");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue fill count lost an item");

endmodule

`default_nettype wire

// ===== rtl/gcwd_back.sv =====
// Back end: normalizes copy geometry and holds the result item for the consumer.
`timescale 1ns / 1ps
`default_nettype none

module gcwd_back import gcwd_pkg::*; #(
    parameter int VRAM_WIDTH  = DEF_VRAM_WIDTH,
    parameter int VRAM_HEIGHT = DEF_VRAM_HEIGHT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire gcwd_item_t  q_item,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_event_res,
    output logic [2:0]       m_cmd_class,
    output logic [3:0]       m_param_count,
    output logic [9:0]       m_src_x,
    output logic [8:0]       m_src_y,
    output logic [9:0]       m_dst_x,
    output logic [8:0]       m_dst_y,
    output logic [10:0]      m_width,
    output logic [9:0]       m_height,
    output logic             m_flush_needed
);

    localparam logic [15:0] FULL_W = 16'(VRAM_WIDTH);
    localparam logic [15:0] FULL_H = 16'(VRAM_HEIGHT);
    localparam logic [15:0] MASK_W = 16'(VRAM_WIDTH - 1);
    localparam logic [15:0] MASK_H = 16'(VRAM_HEIGHT - 1);

    function automatic logic [15:0] norm_size(input logic [15:0] v, input logic [15:0] full,
                                              input logic [15:0] mask);
        logic [15:0] r;
        if (v == 16'd0) begin
            r = full;
        end else begin
            r = ((v - 16'd1) & mask) + 16'd1;
        end
        return r;
    endfunction

    logic        valid_reg;
    gcwd_event_t ev_reg;
    gcwd_class_t cls_reg;
    logic [3:0]  cnt_reg;
    logic        flush_reg;
    logic [9:0]  sx_reg, sx_next;
    logic [8:0]  sy_reg, sy_next;
    logic [9:0]  dx_reg, dx_next;
    logic [8:0]  dy_reg, dy_next;
    logic [10:0] wd_reg, wd_next;
    logic [9:0]  ht_reg, ht_next;
    logic [15:0] wd_full;
    logic [15:0] ht_full;
    logic [15:0] sx_m, sy_m, dx_m, dy_m;

    assign q_pop = q_valid && (!valid_reg || m_ready);

    always_comb begin
        wd_full = norm_size(q_item.sz_lo, FULL_W, MASK_W);
        ht_full = norm_size(q_item.sz_hi, FULL_H, MASK_H);
        sx_m    = q_item.c0_lo & MASK_W;
        sy_m    = q_item.c0_hi & MASK_H;
        dx_m    = q_item.c1_lo & MASK_W;
        dy_m    = q_item.c1_hi & MASK_H;
        sx_next = 10'd0;
        sy_next = 9'd0;
        dx_next = 10'd0;
        dy_next = 9'd0;
        wd_next = 11'd0;
        ht_next = 10'd0;
        unique case (q_item.ev) inside
            EV_VCOPY, EV_TOVRAM, EV_FROMVRAM: begin
                sx_next = sx_m[9:0];
                sy_next = sy_m[8:0];
                wd_next = wd_full[10:0];
                ht_next = ht_full[9:0];
                if (q_item.ev == EV_VCOPY) begin
                    dx_next = dx_m[9:0];
                    dy_next = dy_m[8:0];
                end
            end
            default: begin
                sx_next = 10'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ev_reg    <= q_item.ev;
            cls_reg   <= q_item.cls;
            cnt_reg   <= q_item.cnt;
            flush_reg <= q_item.flush;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            wd_reg    <= wd_next;
            ht_reg    <= ht_next;
        end
    end

    assign m_valid        = valid_reg;
    assign m_event_res    = ev_reg;
    assign m_cmd_class    = cls_reg;
    assign m_param_count  = cnt_reg;
    assign m_src_x        = sx_reg;
    assign m_src_y        = sy_reg;
    assign m_dst_x        = dx_reg;
    assign m_dst_y        = dy_reg;
    assign m_width        = wd_reg;
    assign m_height       = ht_reg;
    assign m_flush_needed = flush_reg;

    a_pending_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && !valid_reg) |=> valid_reg)
        else $error("queued item not moved into the empty output stage");

    a_no_copy_geometry: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.ev != EV_VCOPY) |=> (dx_reg == 10'd0 && dy_reg == 9'd0))
        else $error("destination set on an item that is not a vram copy");

endmodule

`default_nettype wire
